[sv/sparsity_row_slot_table_unit_macros.svh]
// Assertion macros for the sparsity row slot table.
`ifndef SPARSITY_ROW_SLOT_TABLE_UNIT_MACROS_SVH
`define SPARSITY_ROW_SLOT_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clock edge out of reset
`define SRST_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srst assertion failed");
// next-cycle implication
`define SRST_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srst assertion failed");
`else
`define SRST_ASSERT_IMP(lbl, ante, cons)
`define SRST_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/srst_pkg.sv]
// Shared types and codes of the sparsity row slot table.
`timescale 1ns / 1ps

package srst_pkg;

   localparam int MODE_W   = 2;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 8;
   localparam int CNT_W    = 9;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 3;
   localparam int BAND_W   = 8;
   localparam int CSR_IDX_W = 1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ROW_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [BAND_W-1:0]   band_width;
   } rsp_type;

   // outcome of one row scan
   typedef struct packed {
      logic hit;    // first stop is a slot holding the column
      logic open;   // first stop is an empty slot
   } scan_type;

endpackage

[sv/srst_row_mem.sv]
// Row word memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module srst_row_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int WIDTH  = 72
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/srst_slot_scan.sv]
// Row scan: finds the first slot that holds the column or is empty.
`timescale 1ns / 1ps

module srst_slot_scan #(
   parameter int SLOTS  = 8,
   parameter int IDX_W  = 3
) (
   input  logic [SLOTS-1:0]                    slot_valid,
   input  logic [SLOTS-1:0][srst_pkg::COL_W-1:0] slot_col,
   input  logic [srst_pkg::COL_W-1:0]          col,
   output srst_pkg::scan_type                  scan,
   output logic [IDX_W-1:0]                    index
);

   logic [SLOTS-1:0] hit_vec;
   logic [SLOTS-1:0] stop_vec;

   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         hit_vec[k]  = slot_valid[k] && (slot_col[k] == col);
         stop_vec[k] = hit_vec[k] || !slot_valid[k];
      end
   end

   // priority pick, lowest slot wins
   always_comb begin
      scan  = '0;
      index = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (stop_vec[k]) begin
            scan.hit  = hit_vec[k];
            scan.open = !slot_valid[k];
            index     = IDX_W'(k);
         end
      end
   end

endmodule

[sv/sparsity_row_slot_table_unit.sv]
// Top level of the sparsity row slot table.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | srst_pkg::req_type (mode, row, col)
//  rsp     | out       | rsp_valid/rsp_ready  | srst_pkg::rsp_type (status, slot, band_width)
//  csr     | in        | csr_we               | csr_index, csr_wdata (row_count, col_count)
//
// Each item passes through the IDLE and EXEC states: the accept issues the row read to the
// synchronous row memory, then EXEC scans the returned row word and writes it
// back. The next request is taken only once EXEC has fired and the unit is back in IDLE.
// Reset needs no clearing pass: a per-row valid flag marks rows written since
// the last clear; other rows read as the pattern built at clear time.
// A result that is not taken holds the scan stage; one finished result
// may wait in the output register while the next request is accepted.
`timescale 1ns / 1ps
`include "sparsity_row_slot_table_unit_macros.svh"

module sparsity_row_slot_table_unit #(
   parameter int MAX_DIM       = 256,
   parameter int SLOTS_PER_ROW = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  srst_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output srst_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [srst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srst_pkg::CNT_W-1:0]         csr_wdata
);

   // rows reachable through an 8-bit row index
   localparam int ROW_SPAN = 1 << srst_pkg::ROW_W;
   localparam int ROWS     = (MAX_DIM < ROW_SPAN) ? MAX_DIM : ROW_SPAN;
   localparam int ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W    = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
   localparam int WORD_W   = SLOTS_PER_ROW * (1 + srst_pkg::COL_W);
   // largest value a 9-bit count can take after saturation to MAX_DIM
   localparam int CNT_MAX  = (1 << srst_pkg::CNT_W) - 1;
   localparam int CNT_CAP  = (MAX_DIM < CNT_MAX) ? MAX_DIM : CNT_MAX;
   localparam int CNT_RST  = 256;
   localparam int EFF_RST  = (CNT_RST < CNT_CAP) ? CNT_RST : CNT_CAP;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   localparam int CW = srst_pkg::COL_W;

   // control
   logic state_ff, state_in;
   logic accept, exec_fire;

   // captured request
   srst_pkg::req_type req_ff;

   // configuration
   logic [srst_pkg::CNT_W-1:0] row_count_ff, col_count_ff;
   logic [srst_pkg::CNT_W-1:0] eff_rows, eff_cols;

   // pattern bookkeeping
   logic [srst_pkg::BAND_W-1:0] max_dist_ff, max_dist_in;
   logic                        clr_square_ff;     // square when last cleared
   logic [srst_pkg::CNT_W-1:0]  clr_rows_ff;       // effective rows when last cleared
   logic [ROWS-1:0]             row_valid_ff;

   // output register
   logic              rsp_valid_ff;
   srst_pkg::rsp_type rsp_data_ff;

   // row word path
   logic [ADDR_W-1:0]                  cur_addr;
   logic [WORD_W-1:0]                  mem_rd, mem_wr;
   logic [SLOTS_PER_ROW-1:0]           cur_valid, new_valid;
   logic [SLOTS_PER_ROW-1:0][CW-1:0]   cur_col, new_col;
   srst_pkg::scan_type                 scan;
   logic [IDX_W-1:0]                   scan_idx;

   // decision
   logic                          in_range;
   logic [srst_pkg::BAND_W-1:0]   row_col_gap;
   logic [srst_pkg::STATUS_W-1:0] status_c;
   logic [srst_pkg::SLOT_W-1:0]   slot_c;
   logic                          do_write;
   logic                          do_clear;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // scan stage proceeds only when the output register is free or draining
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // effective counts, saturated to MAX_DIM
   assign eff_rows = (row_count_ff > srst_pkg::CNT_W'(CNT_CAP)) ?
                     srst_pkg::CNT_W'(CNT_CAP) : row_count_ff;
   assign eff_cols = (col_count_ff > srst_pkg::CNT_W'(CNT_CAP)) ?
                     srst_pkg::CNT_W'(CNT_CAP) : col_count_ff;

   assign cur_addr = req_ff.row[ADDR_W-1:0];

   srst_row_mem #(
      .DEPTH  (ROWS),
      .ADDR_W (ADDR_W),
      .WIDTH  (WORD_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_data.row[ADDR_W-1:0]),
      .rd_data (mem_rd),
      .wr_en   (exec_fire && do_write),
      .wr_addr (cur_addr),
      .wr_data (mem_wr)
   );

   // A row untouched since the last clear reads as its cleared pattern:
   // diagonal in slot 0 when the matrix was square, else empty.
   always_comb begin
      if (row_valid_ff[cur_addr]) begin
         for (int k = 0; k < SLOTS_PER_ROW; k++) begin
            cur_valid[k] = mem_rd[k];
            cur_col[k]   = mem_rd[SLOTS_PER_ROW + k*CW +: CW];
         end
      end else begin
         cur_valid    = '0;
         cur_col      = '0;
         cur_valid[0] = clr_square_ff && ({1'b0, req_ff.row} < clr_rows_ff);
         cur_col[0]   = req_ff.row;
      end
   end

   srst_slot_scan #(
      .SLOTS (SLOTS_PER_ROW),
      .IDX_W (IDX_W)
   ) u_slot_scan (
      .slot_valid (cur_valid),
      .slot_col   (cur_col),
      .col        (req_ff.col),
      .scan       (scan),
      .index      (scan_idx)
   );

   // write-back word: the row with the new column placed at the open slot
   always_comb begin
      new_valid = cur_valid;
      new_col   = cur_col;
      new_valid[scan_idx] = 1'b1;
      new_col[scan_idx]   = req_ff.col;
      for (int k = 0; k < SLOTS_PER_ROW; k++) begin
         mem_wr[k]                          = new_valid[k];
         mem_wr[SLOTS_PER_ROW + k*CW +: CW] = new_col[k];
      end
   end

   assign in_range = ({1'b0, req_ff.row} < eff_rows) && ({1'b0, req_ff.col} < eff_cols);
   assign row_col_gap = (req_ff.row > req_ff.col) ? (req_ff.row - req_ff.col)
                                                  : (req_ff.col - req_ff.row);

   always_comb begin
      status_c = srst_pkg::STAT_RANGE;
      slot_c   = '0;
      do_write = 1'b0;
      do_clear = 1'b0;
      unique case (req_ff.mode) inside
         srst_pkg::MODE_ADD, srst_pkg::MODE_QUERY: begin
            if (!in_range) begin
               status_c = srst_pkg::STAT_RANGE;
            end else if (scan.hit) begin
               status_c = srst_pkg::STAT_FOUND;
               slot_c   = srst_pkg::SLOT_W'(scan_idx);
            end else if (scan.open && (req_ff.mode == srst_pkg::MODE_ADD)) begin
               status_c = srst_pkg::STAT_INSERTED;
               slot_c   = srst_pkg::SLOT_W'(scan_idx);
               do_write = 1'b1;
            end else if (req_ff.mode == srst_pkg::MODE_ADD) begin
               status_c = srst_pkg::STAT_ROW_FULL;
            end else begin
               status_c = srst_pkg::STAT_NOT_FOUND;
            end
         end
         srst_pkg::MODE_CLEAR: begin
            status_c = srst_pkg::STAT_CLEARED;
            do_clear = 1'b1;
         end
         default: status_c = srst_pkg::STAT_RANGE;  // unused mode
      endcase
   end

   always_comb begin
      max_dist_in = max_dist_ff;
      if (exec_fire) begin
         if (do_clear) begin
            max_dist_in = '0;
         end else if (do_write && (row_col_gap > max_dist_ff)) begin
            max_dist_in = row_col_gap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_count_ff  <= srst_pkg::CNT_W'(CNT_RST);
         col_count_ff  <= srst_pkg::CNT_W'(CNT_RST);
         max_dist_ff   <= '0;
         clr_square_ff <= 1'b1;
         clr_rows_ff   <= srst_pkg::CNT_W'(EFF_RST);
         row_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         max_dist_ff <= max_dist_in;
         if (csr_we) begin
            unique case (csr_index)
               srst_pkg::CSR_ROW_COUNT: row_count_ff <= csr_wdata;
               srst_pkg::CSR_COL_COUNT: col_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (exec_fire && do_clear) begin
            clr_square_ff <= (eff_rows == eff_cols);
            clr_rows_ff   <= eff_rows;
            row_valid_ff  <= '0;
         end else if (exec_fire && do_write) begin
            row_valid_ff[cur_addr] <= 1'b1;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (exec_fire) begin
         rsp_data_ff.status     <= status_c;
         rsp_data_ff.slot       <= slot_c;
         rsp_data_ff.band_width <= max_dist_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted request always moves to the scan stage
   `SRST_ASSERT_NXT(a_accept_to_exec, accept, state_ff == S_EXEC)
   // a finished scan always leaves a result in the output register
   `SRST_ASSERT_NXT(a_exec_to_rsp, exec_fire, rsp_valid_ff)
   // bandwidth only drops through a clear
   `SRST_ASSERT_NXT(a_band_monotonic, !(exec_fire && do_clear), max_dist_ff >= $past(max_dist_ff))

endmodule
